// File: sv/mvrw_pkg.sv
// shared types, constants and level coding for the mixer volume register writer
`default_nettype none
package mvrw_pkg;

   // sequencer states
   typedef enum logic {
      ST_IDLE,
      ST_RUN
   } state_type;

   // level scaling: (31 * pct + 50) / 100 with pct clamped to 100
   localparam int unsigned MAX_PCT     = 100;
   localparam int unsigned SCALE_MUL   = 31;
   localparam int unsigned SCALE_BIAS  = 50;
   // reciprocal of 100: floor(x * 1311 / 2**17) equals x / 100 for x below 3151
   localparam int unsigned RECIP_MUL   = 1311;
   localparam int unsigned RECIP_SHIFT = 17;

   localparam int unsigned PCT_W   = 7;   // clamped percent
   localparam int unsigned NUM_W   = 12;  // 31 * pct + 50
   localparam int unsigned RECIP_W = 11;
   localparam int unsigned PROD_W  = NUM_W + RECIP_W;
   localparam int unsigned SCALE_W = 5;   // scaled level 0..31

   // mixer register addresses within a channel's block of eight
   localparam logic [2:0] ADDR_CTRL_LEFT  = 3'h0;
   localparam logic [2:0] ADDR_CTRL_RIGHT = 3'h1;
   localparam logic [2:0] ADDR_ATTN_LEFT  = 3'h2;
   localparam logic [2:0] ADDR_ATTN_RIGHT = 3'h3;

   // routing values written to the control registers
   localparam logic [7:0] ROUTE_ONE = 8'h01;
   localparam logic [7:0] ROUTE_TWO = 8'h02;

   // operation codes
   localparam logic OP_SET  = 1'b0;
   localparam logic OP_READ = 1'b1;

   // flip mask reset: channels 3 and 5
   localparam logic [5:0] FLIP_MASK_RESET = 6'd40;

   // exponent / mantissa code of a 5-bit scaled level, zero stays zero
   function automatic logic [7:0] code_level(input logic [SCALE_W-1:0] s);
      logic [2:0] e;
      logic [3:0] m;
      e = 3'd0;
      m = 4'd0;
      if (s[4]) begin
         e = 3'd7;
         m = s[3:0];
      end else if (s[3]) begin
         e = 3'd6;
         m = {s[2:0], 1'b0};
      end else if (s[2]) begin
         e = 3'd5;
         m = {s[1:0], 2'b00};
      end else if (s[1]) begin
         e = 3'd4;
         m = {s[0], 3'b000};
      end else if (s[0]) begin
         e = 3'd3;
         m = 4'd0;
      end
      return (s == '0) ? 8'h00 : {1'b0, e, m};
   endfunction

endpackage
`default_nettype wire

// File: sv/mixer_volume_register_writer.sv
// A taken request moves the sequencer to ST_RUN, which loads each result word once the output
// register is free. A set to a valid channel gives eight words from one step counter over the
// single output register, one word a cycle while rsp_ready is high; any other request gives one.
// The shared scaling multiplier is used once per side, on the first word of that side.
// Reset clears the level table and the sequencer and loads flip_mask with 40.
`default_nettype none
module mixer_volume_register_writer
   import mvrw_pkg::*;
#(
   parameter int unsigned NUM_CHANNELS = 6
) (
   input  wire logic        clock,
   input  wire logic        reset,
   // request channel
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic        req_operation,
   input  wire logic [2:0]  req_channel_index,
   input  wire logic [7:0]  req_left_level,
   input  wire logic [7:0]  req_right_level,
   // response channel
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic             rsp_bus_valid,
   output logic             rsp_to_data_port,
   output logic [7:0]       rsp_bus_byte,
   output logic [15:0]      rsp_stored_levels,
   output logic             rsp_last,
   // configuration
   input  wire logic        csr_wr_en,
   input  wire logic [5:0]  csr_wr_data
);

   localparam int unsigned IDX_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

   state_type         state_ff, state_in;
   logic [2:0]        step_ff, step_in;
   logic              single_ff, single_in;
   logic              range_ff, range_in;
   logic [2:0]        chan_ff, chan_in;
   logic [PCT_W-1:0]  left_ff, left_in;
   logic [PCT_W-1:0]  right_ff, right_in;
   logic              flip_ff, flip_in;
   logic [SCALE_W-1:0] scale_ff, scale_in;
   logic [5:0]        flip_mask_ff, flip_mask_in;
   logic [15:0]       level_table_ff [NUM_CHANNELS];

   logic              rsp_valid_ff, rsp_valid_in;
   logic              bus_valid_ff, bus_valid_in;
   logic              to_data_ff, to_data_in;
   logic [7:0]        bus_byte_ff, bus_byte_in;
   logic [15:0]       levels_ff, levels_in;
   logic              last_ff, last_in;

   logic              accept;
   logic              out_free;
   logic              load;
   logic              final_word;
   logic              req_in_range;
   logic [PCT_W-1:0]  req_left_clamp;
   logic [PCT_W-1:0]  req_right_clamp;
   logic [7:0]        flip_ext;
   logic [PCT_W-1:0]  unit_pct;
   logic [NUM_W-1:0]  unit_num;
   logic [PROD_W-1:0] unit_prod;
   logic [7:0]        chan_base;
   logic [15:0]       packed_pair;
   logic [7:0]        route_left;
   logic [7:0]        route_right;

   // handshake
   assign accept   = req_valid && req_ready;
   assign out_free = !rsp_valid_ff || rsp_ready;
   assign final_word = single_ff || (step_ff == 3'd7);

   // request decode
   assign req_in_range    = ({1'b0, req_channel_index} < 4'(NUM_CHANNELS));
   assign req_left_clamp  = (req_left_level > 8'(MAX_PCT)) ? PCT_W'(MAX_PCT)
                                                           : req_left_level[PCT_W-1:0];
   assign req_right_clamp = (req_right_level > 8'(MAX_PCT)) ? PCT_W'(MAX_PCT)
                                                            : req_right_level[PCT_W-1:0];
   assign flip_ext        = {2'b00, flip_mask_ff};

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_RUN;
            end
         end
         ST_RUN: begin
            if (out_free && final_word) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // sequencer outputs
   always_comb begin
      req_ready = 1'b0;
      load      = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
         end
         ST_RUN: begin
            load = out_free;
         end
         default: begin
            req_ready = 1'b0;
         end
      endcase
   end

   // request capture and step counter
   always_comb begin
      step_in   = step_ff;
      single_in = single_ff;
      range_in  = range_ff;
      chan_in   = chan_ff;
      left_in   = left_ff;
      right_in  = right_ff;
      flip_in   = flip_ff;
      if (accept) begin
         step_in   = 3'd0;
         single_in = (req_operation == OP_READ) || !req_in_range;
         range_in  = req_in_range;
         chan_in   = req_channel_index;
         left_in   = req_left_clamp;
         right_in  = req_right_clamp;
         flip_in   = flip_ext[req_channel_index];
      end else if (load) begin
         step_in = step_ff + 3'd1;
      end
   end

   // shared scaling unit: one side per use, on the first word of that side
   assign unit_pct  = step_ff[2] ? right_ff : left_ff;
   assign unit_num  = NUM_W'(SCALE_MUL) * NUM_W'(unit_pct) + NUM_W'(SCALE_BIAS);
   assign unit_prod = PROD_W'(unit_num) * PROD_W'(RECIP_MUL);

   always_comb begin
      scale_in = scale_ff;
      if (load && !single_ff && (step_ff[1:0] == 2'b00)) begin
         scale_in = unit_prod[RECIP_SHIFT +: SCALE_W];
      end
   end

   // word assembly
   assign chan_base   = {2'b00, chan_ff, 3'b000};
   assign packed_pair = {1'b0, right_ff, 1'b0, left_ff};
   assign route_left  = flip_ff ? ROUTE_TWO : ROUTE_ONE;
   assign route_right = flip_ff ? ROUTE_ONE : ROUTE_TWO;

   always_comb begin
      bus_valid_in = 1'b1;
      to_data_in   = step_ff[0];
      levels_in    = packed_pair;
      last_in      = final_word;
      bus_byte_in  = 8'h00;
      if (single_ff) begin
         bus_valid_in = 1'b0;
         to_data_in   = 1'b0;
         levels_in    = range_ff ? level_table_ff[chan_ff[IDX_W-1:0]] : 16'h0000;
      end else begin
         case (step_ff)
            3'd0:    bus_byte_in = chan_base | {5'b0, ADDR_CTRL_LEFT};
            3'd1:    bus_byte_in = route_left;
            3'd2:    bus_byte_in = chan_base | {5'b0, ADDR_ATTN_LEFT};
            3'd3:    bus_byte_in = code_level(scale_ff);
            3'd4:    bus_byte_in = chan_base | {5'b0, ADDR_CTRL_RIGHT};
            3'd5:    bus_byte_in = route_right;
            3'd6:    bus_byte_in = chan_base | {5'b0, ADDR_ATTN_RIGHT};
            3'd7:    bus_byte_in = code_level(scale_ff);
            default: bus_byte_in = 8'h00;
         endcase
      end
   end

   // output register valid
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // configuration register
   assign flip_mask_in = csr_wr_en ? csr_wr_data : flip_mask_ff;

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         step_ff      <= 3'd0;
         rsp_valid_ff <= 1'b0;
         flip_mask_ff <= FLIP_MASK_RESET;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
         flip_mask_ff <= flip_mask_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      single_ff <= single_in;
      range_ff  <= range_in;
      chan_ff   <= chan_in;
      left_ff   <= left_in;
      right_ff  <= right_in;
      flip_ff   <= flip_in;
      scale_ff  <= scale_in;
      if (load) begin
         bus_valid_ff <= bus_valid_in;
         to_data_ff   <= to_data_in;
         bus_byte_ff  <= bus_byte_in;
         levels_ff    <= levels_in;
         last_ff      <= last_in;
      end
   end

   // level table, written when a set to a valid channel is taken
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_CHANNELS; i++) begin
            level_table_ff[i] <= 16'h0000;
         end
      end else if (accept && (req_operation == OP_SET) && req_in_range) begin
         level_table_ff[req_channel_index[IDX_W-1:0]] <=
            {1'b0, req_right_clamp, 1'b0, req_left_clamp};
      end
   end

   // ports
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_bus_valid     = bus_valid_ff;
   assign rsp_to_data_port  = to_data_ff;
   assign rsp_bus_byte      = bus_byte_ff;
   assign rsp_stored_levels = levels_ff;
   assign rsp_last          = last_ff;

`ifndef SYNTHESIS
   // a taken request starts the sequencer at its first word
   assert property (@(posedge clock) disable iff (reset)
      accept |=> (state_ff == ST_RUN) && (step_ff == 3'd0))
      else $error("sequencer did not start on a taken request");

   // the eighth word of a set is marked last
   assert property (@(posedge clock) disable iff (reset)
      (load && !single_ff && (step_ff == 3'd7)) |=> rsp_valid && rsp_last)
      else $error("final set word not marked last");

   // a set ends on a data port write
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_bus_valid && rsp_last) |-> rsp_to_data_port)
      else $error("last bus word not on data port");

   // no new request while a sequence is running
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_RUN) && !final_word |=> !req_ready)
      else $error("request taken during a sequence");
`endif

endmodule
`default_nettype wire

// File: tb/sv/testbench.sv
// self-checking testbench for the mixer volume register writer
`timescale 1ns / 100ps

module testbench;
   import mvrw_pkg::*;

   localparam int unsigned NUM_CH      = 6;
   localparam int unsigned RANDOM_ITEMS = 140;
   localparam int unsigned MAX_CYCLES  = 200000;

   // one response word as seen on the result channel
   typedef struct {
      logic        bus_valid;
      logic        to_data_port;
      logic [7:0]  bus_byte;
      logic [15:0] stored_levels;
      logic        last;
   } mixer_word_type;

   // predicts response words and compares them with what the block sends
   class level_scoreboard;
      logic [15:0] level_table [NUM_CH];
      logic [5:0]  flip_bits;
      mixer_word_type pending_words [$];
      int unsigned errors;
      int unsigned set_count;
      int unsigned read_count;
      int unsigned bad_channel_count;
      int unsigned checked_count;

      function new();
         foreach (level_table[i]) level_table[i] = '0;
         flip_bits = FLIP_MASK_RESET;
         errors = 0;
         set_count = 0;
         read_count = 0;
         bad_channel_count = 0;
         checked_count = 0;
      endfunction

      function void set_flip(logic [5:0] mask);
         flip_bits = mask;
      endfunction

      function int unsigned pending();
         return pending_words.size();
      endfunction

      // scale percent to 0..31, then exponent / mantissa with zero kept as zero
      function logic [7:0] level_code(logic [6:0] pct);
         int unsigned scaled;
         int unsigned shifts;
         logic [3:0]  expo;
         logic [3:0]  mant;
         scaled = (31 * pct + 50) / 100;
         if (scaled == 0) return 8'h00;
         shifts = 0;
         while (scaled < 16) begin
            scaled = scaled << 1;
            shifts++;
         end
         expo = 4'(7 - shifts);
         mant = 4'(scaled - 16);
         return {expo, mant};
      endfunction

      function logic [6:0] clamp_pct(logic [7:0] v);
         return (v > 8'd100) ? 7'd100 : v[6:0];
      endfunction

      function void push_word(logic bv, logic dp, logic [7:0] b, logic [15:0] lv, logic lst);
         mixer_word_type w;
         w.bus_valid     = bv;
         w.to_data_port  = dp;
         w.bus_byte      = b;
         w.stored_levels = lv;
         w.last          = lst;
         pending_words.push_back(w);
      endfunction

      // accepted request: queue the words it must produce and update the table
      function void note_request(logic op, logic [2:0] ch, logic [7:0] left_in,
                                 logic [7:0] right_in);
         logic [6:0]  left_pct;
         logic [6:0]  right_pct;
         logic [15:0] packed_pair;
         logic [7:0]  base;
         logic [7:0]  left_route;
         logic [7:0]  right_route;
         if (ch >= NUM_CH) begin
            bad_channel_count++;
            push_word(1'b0, 1'b0, 8'h00, 16'h0000, 1'b1);
         end else if (op == OP_READ) begin
            read_count++;
            push_word(1'b0, 1'b0, 8'h00, level_table[ch], 1'b1);
         end else begin
            set_count++;
            left_pct    = clamp_pct(left_in);
            right_pct   = clamp_pct(right_in);
            packed_pair = {1'b0, right_pct, 1'b0, left_pct};
            base        = {2'b00, ch, 3'b000};
            left_route  = flip_bits[ch] ? ROUTE_TWO : ROUTE_ONE;
            right_route = flip_bits[ch] ? ROUTE_ONE : ROUTE_TWO;
            push_word(1'b1, 1'b0, base | {5'b0, ADDR_CTRL_LEFT}, packed_pair, 1'b0);
            push_word(1'b1, 1'b1, left_route, packed_pair, 1'b0);
            push_word(1'b1, 1'b0, base | {5'b0, ADDR_ATTN_LEFT}, packed_pair, 1'b0);
            push_word(1'b1, 1'b1, level_code(left_pct), packed_pair, 1'b0);
            push_word(1'b1, 1'b0, base | {5'b0, ADDR_CTRL_RIGHT}, packed_pair, 1'b0);
            push_word(1'b1, 1'b1, right_route, packed_pair, 1'b0);
            push_word(1'b1, 1'b0, base | {5'b0, ADDR_ATTN_RIGHT}, packed_pair, 1'b0);
            push_word(1'b1, 1'b1, level_code(right_pct), packed_pair, 1'b1);
            level_table[ch] = packed_pair;
         end
      endfunction

      // compare one received word with the oldest expected one
      function void check_word(mixer_word_type got);
         mixer_word_type exp_w;
         if (pending_words.size() == 0) begin
            $display("%0t: unexpected word bus_valid=%0b data=%0b byte=%02h levels=%04h last=%0b",
                     $time, got.bus_valid, got.to_data_port, got.bus_byte,
                     got.stored_levels, got.last);
            errors++;
            return;
         end
         exp_w = pending_words.pop_front();
         checked_count++;
         if (got.bus_valid !== exp_w.bus_valid) begin
            $display("%0t: bus_valid expected %0b actual %0b", $time, exp_w.bus_valid,
                     got.bus_valid);
            errors++;
         end
         if (got.to_data_port !== exp_w.to_data_port) begin
            $display("%0t: to_data_port expected %0b actual %0b", $time, exp_w.to_data_port,
                     got.to_data_port);
            errors++;
         end
         if (got.bus_byte !== exp_w.bus_byte) begin
            $display("%0t: bus_byte expected %02h actual %02h", $time, exp_w.bus_byte,
                     got.bus_byte);
            errors++;
         end
         if (got.stored_levels !== exp_w.stored_levels) begin
            $display("%0t: stored_levels expected %04h actual %04h", $time,
                     exp_w.stored_levels, got.stored_levels);
            errors++;
         end
         if (got.last !== exp_w.last) begin
            $display("%0t: last expected %0b actual %0b", $time, exp_w.last, got.last);
            errors++;
         end
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   logic        req_operation;
   logic [2:0]  req_channel_index;
   logic [7:0]  req_left_level;
   logic [7:0]  req_right_level;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic        rsp_bus_valid;
   logic        rsp_to_data_port;
   logic [7:0]  rsp_bus_byte;
   logic [15:0] rsp_stored_levels;
   logic        rsp_last;
   logic        csr_wr_en;
   logic [5:0]  csr_wr_data;

   level_scoreboard sb;
   bit              steady = 1'b0;
   int unsigned     stall_cnt = 0;
   int unsigned     cycles = 0;

   mixer_volume_register_writer #(
      .NUM_CHANNELS(NUM_CH)
   ) i_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_operation    (req_operation),
      .req_channel_index(req_channel_index),
      .req_left_level   (req_left_level),
      .req_right_level  (req_right_level),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_bus_valid    (rsp_bus_valid),
      .rsp_to_data_port (rsp_to_data_port),
      .rsp_bus_byte     (rsp_bus_byte),
      .rsp_stored_levels(rsp_stored_levels),
      .rsp_last         (rsp_last),
      .csr_wr_en        (csr_wr_en),
      .csr_wr_data      (csr_wr_data)
   );

   // clock
   always #1 clock = ~clock;

   // run limit
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > MAX_CYCLES) begin
         $display("timeout after %0d cycles", cycles);
         $display("status: fail");
         $finish;
      end
   end

   // response back-pressure in random bursts
   always @(posedge clock) begin
      if (stall_cnt > 0) begin
         stall_cnt <= stall_cnt - 1;
         rsp_ready <= (stall_cnt == 1);
      end else if (!steady && $urandom_range(0, 4) == 0) begin
         stall_cnt <= $urandom_range(1, 6);
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   // response monitor
   always @(posedge clock) begin
      mixer_word_type got;
      if (!reset && rsp_valid && rsp_ready) begin
         got.bus_valid     = rsp_bus_valid;
         got.to_data_port  = rsp_to_data_port;
         got.bus_byte      = rsp_bus_byte;
         got.stored_levels = rsp_stored_levels;
         got.last          = rsp_last;
         sb.check_word(got);
      end
   end

   // present one request word and hold it until taken; valid stays high afterwards
   task automatic send_request(input logic op, input logic [2:0] ch, input logic [7:0] left_in,
                               input logic [7:0] right_in);
      req_valid         <= 1'b1;
      req_operation     <= op;
      req_channel_index <= ch;
      req_left_level    <= left_in;
      req_right_level   <= right_in;
      do @(posedge clock); while (!req_ready);
      sb.note_request(op, ch, left_in, right_in);
   endtask

   // random request-side gap
   task automatic maybe_gap();
      if (!steady && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
   endtask

   // stop sending and wait for every expected word
   task automatic drain();
      req_valid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_flip_mask(input logic [5:0] mask);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= mask;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      sb.set_flip(mask);
   endtask

   task automatic send_random();
      logic       op;
      logic [2:0] ch;
      logic [7:0] left_in;
      logic [7:0] right_in;
      op       = ($urandom_range(0, 3) == 0) ? OP_READ : OP_SET;
      ch       = ($urandom_range(0, 9) == 0) ? 3'($urandom_range(6, 7))
                                             : 3'($urandom_range(0, 5));
      left_in  = $urandom_range(0, 1) ? 8'($urandom_range(0, 100))
                                      : 8'($urandom_range(0, 255));
      right_in = $urandom_range(0, 1) ? 8'($urandom_range(0, 100))
                                      : 8'($urandom_range(0, 255));
      maybe_gap();
      send_request(op, ch, left_in, right_in);
   endtask

   // main sequence
   initial begin
      sb                = new();
      reset             = 1'b1;
      req_valid         = 1'b0;
      req_operation     = OP_SET;
      req_channel_index = 3'd0;
      req_left_level    = 8'd0;
      req_right_level   = 8'd0;
      csr_wr_en         = 1'b0;
      csr_wr_data       = 6'd0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: reset flip mask, empty table, level extremes, clamping, bad channels
      send_request(OP_READ, 3'd0, 8'd0, 8'd0);
      send_request(OP_SET, 3'd0, 8'd0, 8'd0);
      send_request(OP_SET, 3'd1, 8'd100, 8'd100);
      send_request(OP_SET, 3'd2, 8'd255, 8'd255);
      send_request(OP_SET, 3'd3, 8'd1, 8'd2);
      send_request(OP_SET, 3'd4, 8'd101, 8'd50);
      send_request(OP_SET, 3'd5, 8'd3, 8'd7);
      send_request(OP_SET, 3'd1, 8'd128, 8'd200);
      send_request(OP_SET, 3'd2, 8'd16, 8'd99);
      for (int c = 0; c < 6; c++) send_request(OP_READ, c[2:0], 8'hff, 8'h00);
      send_request(OP_SET, 3'd6, 8'd50, 8'd50);
      send_request(OP_SET, 3'd7, 8'd255, 8'd255);
      send_request(OP_READ, 3'd6, 8'd0, 8'd0);
      send_request(OP_READ, 3'd7, 8'd0, 8'd0);
      drain();

      // random phases over several flip masks, the last at full rate
      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: write_flip_mask(6'd0);
            1: write_flip_mask(6'd63);
            default: write_flip_mask(6'($urandom_range(0, 63)));
         endcase
         steady = (phase == 3);
         for (int n = 0; n < RANDOM_ITEMS / 4; n++) send_random();
         drain();
      end

      repeat (10) @(posedge clock);
      $display("covered %0d level writes, %0d readbacks, %0d bad-channel requests",
               sb.set_count, sb.read_count, sb.bad_channel_count);
      $display("checked %0d response words across five flip mask settings", sb.checked_count);
      if (sb.errors == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule
